// File: rtl/core/multiword_fixed_point_limb_alu_assert.svh
// Concurrent assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef MULTIWORD_FIXED_POINT_LIMB_ALU_ASSERT_SVH
`define MULTIWORD_FIXED_POINT_LIMB_ALU_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MFLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mfla_pkg.sv
`timescale 1ns / 1ps

package mfla_pkg;

  localparam int WORD_W    = 32;
  localparam int S_TDATA_W = 3 * WORD_W;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 2 * WORD_W;
  localparam int M_TUSER_W = 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage

// File: rtl/core/multiword_fixed_point_limb_alu.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tdata: limb_a[31:0], limb_b[63:32], scalar_word[95:64]
//                tuser: opcode[1:0], first_limb[2]
// m_axis    out  tdata: result_limb[31:0], carry_out[63:32]; tuser: div_error[0]
//
// Add, subtract and multiply run serially, one bit per cycle. Divide takes the operand
// magnitudes and runs a radix-2 restoring loop over the low half, or over the whole dividend
// when the upper half of its magnitude is not below the divisor; a zero divisor skips it.
// Reset is asynchronous and active low; it clears the running carry to zero.
// A finished result waits in the output register while the next beat is accepted;
// the block holds its last step only if that register is still full.
module multiword_fixed_point_limb_alu #(
  parameter int LIMB_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // limb_a, limb_b, scalar_word
  input  logic [mfla_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode, first_limb
  input  logic [mfla_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_limb, carry_out
  output logic [mfla_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // div_error
  output logic [mfla_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import mfla_pkg::*;

  localparam int N     = LIMB_BITS;
  localparam int CNT_W = $clog2(2 * N + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_N   = CNT_W'(N);
  localparam logic [CNT_W-1:0] CNT_2N  = CNT_W'(2 * N);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_DSIGN,
    ST_DPREP,
    ST_DIV,
    ST_DFIX,
    ST_DONE
  } state_e;

  state_e             st_q;
  logic [N-1:0]       a_q, b_q, w_q, acc_q, lo_q, carry_q;
  logic [2*N-1:0]     x_q;
  logic signed [2:0]  cs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               sub_q, vn_q, dn_q, err_q;
  logic               m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TUSER_W-1:0] m_tuser_q;

  op_e          in_op;
  logic         in_first;
  logic [N-1:0] in_a, in_b, in_w, c_start;

  assign in_op    = op_e'(s_axis_tuser[1:0]);
  assign in_first = s_axis_tuser[2];
  assign in_a     = s_axis_tdata[0 +: N];
  assign in_b     = s_axis_tdata[WORD_W +: N];
  assign in_w     = s_axis_tdata[2*WORD_W +: N];

  // Restart: divide seeds the remainder with the sign of the top limb.
  always_comb begin
    if (in_first) begin
      c_start = (in_op == OP_DIV && in_a[N-1]) ? '1 : '0;
    end else begin
      c_start = carry_q;
    end
  end

  // Add/subtract digit: a + b + c or a - b - c, one bit of each per cycle.
  logic signed [3:0] cs_ext, as_a, as_bc, as_t;
  logic signed [2:0] cs_next;
  logic [N-1:0]      as_carry;
  always_comb begin
    cs_ext  = {cs_q[2], cs_q};
    as_a    = {3'b000, a_q[0]};
    as_bc   = {3'b000, b_q[0]} + {3'b000, acc_q[0]};
    as_t    = sub_q ? (cs_ext + as_a - as_bc) : (cs_ext + as_a + as_bc);
    cs_next = as_t[3:1];
    if (sub_q) begin
      as_carry = N'(cs_next != 3'sd0);
    end else begin
      as_carry = N'(cs_next[1:0]);
    end
  end

  // Shift-add multiply step; the running carry enters one bit per cycle.
  logic [N:0] mul_sum;
  assign mul_sum = {1'b0, acc_q} + (w_q[0] ? {1'b0, a_q} : '0) + (N + 1)'(b_q[0]);

  // Restoring division step.
  logic [N:0]   div_trial, div_diff;
  logic         div_ge;
  logic [N-1:0] div_rem;
  assign div_trial = {acc_q, x_q[2*N-1]};
  assign div_diff  = div_trial - {1'b0, w_q};
  assign div_ge    = div_trial >= {1'b0, w_q};
  assign div_rem   = div_ge ? div_diff[N-1:0] : div_trial[N-1:0];

  logic [2*N-1:0] x_neg;
  logic [N-1:0]   w_neg, q_fix, r_fix;
  logic           hi_lt;
  assign x_neg = ~x_q + (2 * N)'(1);
  assign w_neg = ~w_q + N'(1);
  assign hi_lt = x_q[2*N-1:N] < w_q;
  assign q_fix = (vn_q ^ dn_q) ? (~x_q[N-1:0] + N'(1)) : x_q[N-1:0];
  assign r_fix = vn_q ? (~acc_q + N'(1)) : acc_q;

  logic out_free;
  assign out_free = !m_tvalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      a_q        <= '0;
      b_q        <= '0;
      w_q        <= '0;
      acc_q      <= '0;
      lo_q       <= '0;
      carry_q    <= '0;
      x_q        <= '0;
      cs_q       <= '0;
      cnt_q      <= '0;
      sub_q      <= 1'b0;
      vn_q       <= 1'b0;
      dn_q       <= 1'b0;
      err_q      <= 1'b0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= '0;
    end else begin
      // The done state reloads the output register itself when it drains.
      if (m_tvalid_q && m_axis_tready && st_q != ST_DONE) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            a_q   <= in_a;
            w_q   <= in_w;
            cs_q  <= '0;
            cnt_q <= CNT_N;
            err_q <= 1'b0;
            sub_q <= (in_op == OP_SUB);
            unique case (in_op)
              OP_ADD, OP_SUB: begin
                b_q   <= in_b;
                acc_q <= c_start;
                st_q  <= ST_ADDSUB;
              end
              OP_MUL: begin
                b_q   <= c_start;
                acc_q <= '0;
                st_q  <= ST_MUL;
              end
              OP_DIV: begin
                b_q  <= c_start;
                x_q  <= {c_start, in_a};
                st_q <= ST_DSIGN;
              end
              default: st_q <= ST_IDLE;
            endcase
          end
        end
        ST_ADDSUB: begin
          a_q   <= a_q >> 1;
          b_q   <= b_q >> 1;
          lo_q  <= {as_t[0], lo_q[N-1:1]};
          cs_q  <= cs_next;
          cnt_q <= cnt_q - CNT_ONE;
          if (cnt_q == CNT_ONE) begin
            acc_q <= as_carry;
            st_q  <= ST_DONE;
          end else begin
            acc_q <= acc_q >> 1;
          end
        end
        ST_MUL: begin
          acc_q <= mul_sum[N:1];
          lo_q  <= {mul_sum[0], lo_q[N-1:1]};
          w_q   <= w_q >> 1;
          b_q   <= b_q >> 1;
          cnt_q <= cnt_q - CNT_ONE;
          if (cnt_q == CNT_ONE) begin
            st_q <= ST_DONE;
          end
        end
        ST_DSIGN: begin
          vn_q <= x_q[2*N-1];
          dn_q <= w_q[N-1];
          if (x_q[2*N-1]) begin
            x_q <= x_neg;
          end
          if (w_q[N-1]) begin
            w_q <= w_neg;
          end
          // Zero divisor: quotient 0, remainder kept, flag raised.
          if (w_q == '0) begin
            lo_q  <= '0;
            acc_q <= b_q;
            err_q <= 1'b1;
            st_q  <= ST_DONE;
          end else begin
            st_q <= ST_DPREP;
          end
        end
        ST_DPREP: begin
          // Skip the upper half when it already lies below the divisor.
          if (hi_lt) begin
            acc_q <= x_q[2*N-1:N];
            x_q   <= {x_q[N-1:0], {N{1'b0}}};
            cnt_q <= CNT_N;
          end else begin
            acc_q <= '0;
            cnt_q <= CNT_2N;
          end
          st_q <= ST_DIV;
        end
        ST_DIV: begin
          acc_q <= div_rem;
          x_q   <= {x_q[2*N-2:0], div_ge};
          cnt_q <= cnt_q - CNT_ONE;
          if (cnt_q == CNT_ONE) begin
            st_q <= ST_DFIX;
          end
        end
        ST_DFIX: begin
          lo_q  <= q_fix;
          acc_q <= r_fix;
          st_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata_q  <= {WORD_W'(acc_q), WORD_W'(lo_q)};
            m_tuser_q  <= M_TUSER_W'(err_q);
            m_tvalid_q <= 1'b1;
            carry_q    <= acc_q;
            st_q       <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

// File: rtl/core/mfla_checker.sv
`timescale 1ns / 1ps

module mfla_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mfla_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [mfla_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import mfla_pkg::*;
  `include "multiword_fixed_point_limb_alu_assert.svh"

  logic       s_beat, m_beat;
  logic [1:0] open_q;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  // Track beats taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (s_beat && !m_beat) begin
      open_q <= open_q + 2'd1;
    end else if (m_beat && !s_beat) begin
      open_q <= open_q - 2'd1;
    end
  end

  `MFLA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `MFLA_ASSERT_NEXT(a_one_inflight, s_beat, !s_axis_tready, "second beat taken while busy")
  `MFLA_ASSERT_NOW(a_err_zero_quot, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[WORD_W-1:0] == '0, "divide error with nonzero quotient")
  `MFLA_ASSERT_NOW(a_no_phantom, m_axis_tvalid, open_q != 2'd0, "result without input beat")
  `MFLA_ASSERT_NOW(a_open_bound, 1'b1, open_q != 2'd3, "too many beats outstanding")

endmodule

bind multiword_fixed_point_limb_alu mfla_checker u_mfla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_multiword_fixed_point_limb_alu.sv
`timescale 1ns / 1ps

module tb_multiword_fixed_point_limb_alu;
  import mfla_pkg::*;

  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    bit [31:0] limb;
    bit [31:0] carry;
    bit        div_err;
  } limb_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // limb_a, limb_b, scalar_word
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // opcode, first_limb
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // result_limb, carry_out
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // div_error
  logic [M_TUSER_W-1:0] m_axis_tuser;

  limb_result_t pending_limbs[$];
  bit [31:0]    carry_state = '0;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;

  multiword_fixed_point_limb_alu u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Next result limb and running carry, borrow or remainder for one accepted beat.
  function automatic limb_result_t next_limb_result(input op_e op, input bit first,
                                                    input bit [31:0] a, input bit [31:0] b,
                                                    input bit [31:0] w);
    limb_result_t res;
    bit [31:0]    c;
    bit [63:0]    wide;
    bit [63:0]    vmag;
    bit [63:0]    dmag;
    bit [63:0]    qm;
    bit [63:0]    rm;
    bit           vn;
    bit           dn;
    res = '0;
    c = carry_state;
    if (first) begin
      c = (op == OP_DIV && a[31]) ? 32'hFFFF_FFFF : 32'h0;
    end
    case (op)
      OP_ADD: begin
        wide = 64'(a) + 64'(b) + 64'(c);
        res.limb = wide[31:0];
        res.carry = wide[63:32];
      end
      OP_SUB: begin
        res.limb = a - b - c;
        res.carry = (64'(a) < 64'(b) + 64'(c)) ? 32'd1 : 32'd0;
      end
      OP_MUL: begin
        wide = 64'(a) * 64'(w) + 64'(c);
        res.limb = wide[31:0];
        res.carry = wide[63:32];
      end
      default: begin
        wide = {c, a};
        vn = wide[63];
        dn = w[31];
        vmag = vn ? (~wide + 64'd1) : wide;
        dmag = {32'h0, dn ? (~w + 32'd1) : w};
        if (dmag == 64'd0) begin
          // zero divisor: keep the remainder, flag the error
          res.limb = '0;
          res.carry = c;
          res.div_err = 1'b1;
        end else begin
          qm = vmag / dmag;
          rm = vmag % dmag;
          if (vn != dn) qm = ~qm + 64'd1;
          if (vn) rm = ~rm + 64'd1;
          res.limb = qm[31:0];
          res.carry = rm[31:0];
        end
      end
    endcase
    carry_state = res.carry;
    return res;
  endfunction

  function automatic bit [31:0] rand_limb();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit [31:0] rand_scalar();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(255, 1));
      5: return -32'($urandom_range(255, 1));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_limb(input op_e op, input bit first, input bit [31:0] a,
                           input bit [31:0] b, input bit [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, b, a};
    s_axis_tuser  <= {first, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_limbs = {pending_limbs, next_limb_result(op, first, a, b, w)};
  endtask

  // Drop valid and hold the sender until every expected beat has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_limbs.size() != 0);
  endtask

  task automatic test_add_sub();
    send_limb(OP_ADD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_limb(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_limb(OP_ADD, 1'b0, 32'h0, 32'h0, 32'h0);
    send_limb(OP_SUB, 1'b1, 32'h0, 32'h1, 32'h0);
    // b plus borrow wraps past 32 bits
    send_limb(OP_SUB, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_limb(OP_SUB, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0);
  endtask

  task automatic test_mul();
    send_limb(OP_MUL, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_limb(OP_MUL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_limb(OP_MUL, 1'b0, 32'h1234_5678, 32'h0, 32'h0);
  endtask

  task automatic test_div();
    // negative top limb restarts the remainder as all ones
    send_limb(OP_DIV, 1'b1, 32'h8000_0000, 32'h0, 32'd7);
    send_limb(OP_DIV, 1'b0, 32'h1234_5678, 32'h0, 32'd7);
    send_limb(OP_DIV, 1'b1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    send_limb(OP_DIV, 1'b0, 32'h0, 32'h0, 32'h0);
    send_limb(OP_DIV, 1'b1, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    send_limb(OP_DIV, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_mixed();
    // leave a carry of 0x80000000, then divide by -1 so the quotient wraps
    send_limb(OP_MUL, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0001);
    send_limb(OP_DIV, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_limb(OP_MUL, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_limb(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_limb(OP_SUB, 1'b0, 32'h1, 32'h0, 32'h0);
    send_limb(OP_MUL, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_limb(OP_DIV, 1'b0, 32'h0, 32'h0, 32'h1);
    send_limb(OP_DIV, 1'b1, 32'h0000_0001, 32'h0, 32'h8000_0000);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_limb(op_e'($urandom_range(3)), i == 0, rand_limb(), rand_limb(), rand_scalar());
    end
    wait_all_results();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
    int  sent;
    int  len;
    bit  noise;
    op_e op;
    bit [31:0] w;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(6, 1);
      noise = ($urandom_range(99) < 15);
      op = op_e'($urandom_range(3));
      w = rand_scalar();
      for (int i = 0; i < len; i++) begin
        if (noise) begin
          send_limb(op_e'($urandom_range(3)), 1'($urandom_range(1)), rand_limb(), rand_limb(),
                    rand_scalar());
        end else begin
          send_limb(op, i == 0, rand_limb(), rand_limb(), w);
        end
      end
      sent += len;
    end
    wait_all_results();
  endtask

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    limb_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_limbs.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_limbs.pop_front();
        if (m_axis_tdata[31:0] !== want.limb) begin
          $display("%0t: result_limb expected %h actual %h", $time, want.limb,
                   m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.carry) begin
          $display("%0t: carry_out expected %h actual %h", $time, want.carry,
                   m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.div_err) begin
          $display("%0t: div_error expected %b actual %b", $time, want.div_err,
                   m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 49;
    test_add_sub();
    test_mul();
    test_div();
    test_mixed();
    wait_all_results();
    test_backpressure();
    test_random(12, 49, 200);
    test_random(49, 12, 200);
    test_random(0, 0, 200);
    // let any stray beat surface
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_limbs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
